@@ rtl/sap_pkg.sv @@
// Package with shared constants, the stage record and the arctangent table.
package sap_pkg;

  localparam int unsigned AngleBitsDef   = 16;
  localparam int unsigned DolpFracDef    = 14;
  localparam int unsigned CordicSteps    = 30;
  localparam int unsigned CordicScale    = 40;
  localparam int unsigned XW             = 52;
  localparam int unsigned RemW           = 21;
  localparam int unsigned DenW           = 20;
  localparam int unsigned QuotW          = 50;
  localparam int unsigned SremW          = 27;
  localparam int unsigned RootW          = 25;

  typedef logic [31:0] turn_t;

  typedef struct packed {
    logic                  zero;
    logic [7:0]            inten;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    turn_t                 z;
    logic [RemW-1:0]       rem;
    logic [DenW-1:0]       den;
    logic [QuotW-1:0]      quot;
    logic [SremW-1:0]      srem;
    logic [RootW-1:0]      root;
  } sap_stage_t;

  localparam turn_t AtanTurns [CordicSteps] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335086,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41721,
    32'd20860,     32'd10430,     32'd5215,      32'd2607,     32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81,       32'd40,
    32'd20,        32'd10,        32'd5,         32'd2,        32'd1
  };

endpackage

@@ rtl/sap_cfg_if.sv @@
// Configuration write channel carrying the surface mode.
interface sap_cfg_if;
  logic valid;
  logic ready;
  logic surface_mode;
  modport source (output valid, output surface_mode, input ready);
  modport sink (input valid, input surface_mode, output ready);
endinterface

@@ rtl/sap_in_if.sv @@
// Pixel input channel with the four polarizer intensities.
interface sap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] i0_intensity;
  logic [7:0] i45_intensity;
  logic [7:0] i90_intensity;
  logic [7:0] i135_intensity;
  modport source (output valid, output i0_intensity, output i45_intensity,
                  output i90_intensity, output i135_intensity, input ready);
  modport sink (input valid, input i0_intensity, input i45_intensity,
                input i90_intensity, input i135_intensity, output ready);
endinterface

@@ rtl/sap_out_if.sv @@
// Pixel result channel with intensity, angle, degree and azimuth.
interface sap_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  intensity;
  logic [15:0] aolp;
  logic [15:0] dolp;
  logic [16:0] azimuth;
  modport source (output valid, output intensity, output aolp, output dolp,
                  output azimuth, input ready);
  modport sink (input valid, input intensity, input aolp, input dolp,
                input azimuth, output ready);
endinterface

@@ rtl/sap_cell.sv @@
// One pipeline cell: a CORDIC step, a divide step or a square root step, or a CORDIC step with one of the other two.
module sap_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned DIV_STEPS  = 33,
  parameter int unsigned SQRT_STEPS = 17
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  sap_pkg::sap_stage_t s_i,
  output logic                vld_o,
  output sap_pkg::sap_stage_t s_o
);
  import sap_pkg::*;

  localparam bit DoCordic = (IDX < CordicSteps);
  localparam bit DoDiv    = (IDX < DIV_STEPS);
  localparam bit DoSqrt   = (IDX >= DIV_STEPS) && (IDX < DIV_STEPS + SQRT_STEPS);
  localparam int unsigned CIdx = DoCordic ? IDX : 0;
  localparam int unsigned PairLo = DoSqrt ? 2 * (DIV_STEPS + SQRT_STEPS - 1 - IDX) : 0;

  sap_stage_t            s_d;
  sap_stage_t            s_q;
  logic                  vld_q;
  logic signed [XW-1:0]  xs;
  logic signed [XW-1:0]  ys;
  logic [RemW-1:0]       rsh;
  logic                  qbit;
  logic [SremW+1:0]      tmp;
  logic [SremW+1:0]      trial;

  always_comb begin
    s_d   = s_i;
    xs    = s_i.x >>> CIdx;
    ys    = s_i.y >>> CIdx;
    rsh   = (IDX == 0) ? s_i.rem : {s_i.rem[RemW-2:0], 1'b0};
    qbit  = (rsh >= {1'b0, s_i.den});
    tmp   = {s_i.srem, s_i.quot[PairLo +: 2]};
    trial = (SremW + 2)'({s_i.root, 2'b01});
    if (DoCordic) begin
      if (!s_i.y[XW-1]) begin
        s_d.x = s_i.x + ys;
        s_d.y = s_i.y - xs;
        s_d.z = s_i.z + AtanTurns[CIdx];
      end else begin
        s_d.x = s_i.x - ys;
        s_d.y = s_i.y + xs;
        s_d.z = s_i.z - AtanTurns[CIdx];
      end
    end
    if (DoDiv) begin
      s_d.rem  = qbit ? (rsh - {1'b0, s_i.den}) : rsh;
      s_d.quot = {s_i.quot[QuotW-2:0], qbit};
    end
    if (DoSqrt) begin
      if (tmp >= trial) begin
        s_d.srem = SremW'(tmp - trial);
        s_d.root = {s_i.root[RootW-2:0], 1'b1};
      end else begin
        s_d.srem = tmp[SremW-1:0];
        s_d.root = {s_i.root[RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  assign vld_o = vld_q;
  assign s_o   = s_q;

endmodule

@@ rtl/stokes_aolp_dolp_pixel.sv @@
// Top level: per-pixel linear Stokes intensity, AoLP, DoLP and azimuth.
// Channel   Dir  Beat contents
// cfg_i     in   surface_mode
// in_i      in   i0/i45/i90/i135 intensities
// out_o     out  intensity, aolp, dolp, azimuth
// One beat is accepted per cycle while out_o is not stalled; results pass the
// input register, the chain of cells and the output register in that order.
// The chain is as long as the divide and square root cells or the CORDIC cells, if longer.
// Reset clears all valid bits and the mode; a stall on out_o freezes the chain.
module stokes_aolp_dolp_pixel #(
  parameter int unsigned ANGLE_BITS     = sap_pkg::AngleBitsDef,
  parameter int unsigned DOLP_FRAC_BITS = sap_pkg::DolpFracDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sap_cfg_if.sink    cfg_i,
  sap_in_if.sink     in_i,
  sap_out_if.source  out_o
);
  import sap_pkg::*;

  localparam int unsigned DivSteps  = 2 * DOLP_FRAC_BITS + 5;
  localparam int unsigned SqrtSteps = DOLP_FRAC_BITS + 3;
  localparam int unsigned NCells = (DivSteps + SqrtSteps > CordicSteps) ?
                                   DivSteps + SqrtSteps : CordicSteps;
  localparam int unsigned AW = (ANGLE_BITS > 17) ? ANGLE_BITS + 1 : 18;
  localparam int unsigned DRW = DOLP_FRAC_BITS + 3;
  localparam int unsigned DW = (DRW > 17) ? DRW : 17;

  logic                  mode_q;
  logic                  en;
  logic [NCells:0]       vld;
  sap_stage_t            stg [NCells+1];
  sap_stage_t            s0_d;
  logic                  s0_vld_q;
  sap_stage_t            s0_q;

  logic [9:0]            sum;
  logic [9:0]            half;
  logic signed [8:0]     dx;
  logic signed [8:0]     dy;
  logic [7:0]            ax;
  logic [7:0]            ay;
  logic signed [XW-1:0]  dxw;
  logic signed [XW-1:0]  dyw;

  sap_stage_t            fin;
  logic [32:0]           zr;
  logic [ANGLE_BITS-1:0] ang;
  logic [AW-1:0]         angw;
  logic [AW-1:0]         azw;
  logic [DRW:0]          rp;
  logic [DW-1:0]         dvw;

  logic                  out_valid_q;
  logic [7:0]            inten_q;
  logic [15:0]           aolp_q;
  logic [15:0]           dolp_q;
  logic [16:0]           azim_q;

  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.surface_mode;
    end
  end

  always_comb begin
    sum  = 10'(in_i.i0_intensity) + 10'(in_i.i45_intensity) +
           10'(in_i.i90_intensity) + 10'(in_i.i135_intensity);
    dx   = $signed({1'b0, in_i.i0_intensity}) - $signed({1'b0, in_i.i90_intensity});
    dy   = $signed({1'b0, in_i.i45_intensity}) - $signed({1'b0, in_i.i135_intensity});
    ax   = dx[8] ? 8'(-dx) : dx[7:0];
    ay   = dy[8] ? 8'(-dy) : dy[7:0];
    dxw  = XW'(dx);
    dyw  = XW'(dy);
    half = {1'b0, sum[9:1]};
    if (sum[0] && half[0]) begin
      half = half + 10'd1;
    end
    s0_d       = '0;
    s0_d.zero  = (sum == 10'd0) || ((dx == 9'sd0) && (dy == 9'sd0));
    s0_d.inten = (half > 10'd255) ? 8'd255 : half[7:0];
    s0_d.x     = (dx[8] ? -dxw : dxw) <<< CordicScale;
    s0_d.y     = (dx[8] ? -dyw : dyw) <<< CordicScale;
    s0_d.z     = dx[8] ? 32'h8000_0000 : 32'h0;
    s0_d.rem   = RemW'({1'b0, 16'(ax * ax)} + {1'b0, 16'(ay * ay)});
    s0_d.den   = 20'(sum * sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s0_d;
    end
  end

  assign vld[0] = s0_vld_q;
  assign stg[0] = s0_q;

  for (genvar k = 0; k < NCells; k++) begin : g_cell
    sap_cell #(
      .IDX       (k),
      .DIV_STEPS (DivSteps),
      .SQRT_STEPS(SqrtSteps)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (vld[k]),
      .s_i   (stg[k]),
      .vld_o (vld[k+1]),
      .s_o   (stg[k+1])
    );
  end

  always_comb begin
    fin  = stg[NCells];
    zr   = {1'b0, fin.z} + (33'd1 << (31 - ANGLE_BITS));
    ang  = fin.zero ? '0 : zr[32-ANGLE_BITS +: ANGLE_BITS];
    angw = AW'(ang);
    azw  = angw + (mode_q ? (AW'(1) << (ANGLE_BITS - 1)) : '0);
    rp   = {1'b0, fin.root[DRW-1:0]} + (DRW + 1)'(1);
    dvw  = fin.zero ? '0 : DW'(rp[DRW:1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld[NCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inten_q <= fin.inten;
      aolp_q  <= angw[15:0];
      dolp_q  <= (dvw > DW'(16'hFFFF)) ? 16'hFFFF : dvw[15:0];
      azim_q  <= azw[16:0];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.intensity = inten_q;
  assign out_o.aolp      = aolp_q;
  assign out_o.dolp      = dolp_q;
  assign out_o.azimuth   = azim_q;

  localparam logic [16:0] DolpMax = (DOLP_FRAC_BITS < 15) ?
                                    17'(1 << (DOLP_FRAC_BITS + 1)) : 17'h0FFFF;

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.valid && in_i.ready && out_o.valid && !out_o.ready))
    else $error("input beat accepted while output is stalled");

  a_dolp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ({1'b0, out_o.dolp} <= DolpMax))
    else $error("dolp above 2.0");

  a_last_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld[NCells] && en) |=> out_o.valid)
    else $error("finished beat lost before output register");

endmodule
